[src/hpf_pkg.sv]
// Shared types, constants and the text lookup for the hex pointer formatter.
// Used by hpf_front, hpf_queue, hpf_back and the top level.
package hpf_pkg;

  localparam int PTR_W        = 64;
  localparam int WIDTH_W      = 7;
  localparam int TLEN_W       = 5;
  localparam int CHAR_W       = 8;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 16;
  localparam int DEF_MAX_FIELD_WIDTH = 64;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_I      = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L      = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_HEX_A_OFS = 8'h57;  // 'a' - 10

  localparam logic [TLEN_W-1:0] NIL_LEN = 5'd5;

  // One classified item as it waits between front and back
  typedef struct packed {
    logic [PTR_W-1:0]   value;
    logic               is_nil;
    logic [TLEN_W-1:0]  tlen;
    logic [WIDTH_W-1:0] pad;
    logic [WIDTH_W-1:0] total;
    logic               left;
  } desc_t;

  // Character at position j of the unpadded text
  function automatic logic [CHAR_W-1:0] txt_char(desc_t d, logic [TLEN_W-1:0] j);
    logic [TLEN_W-1:0] nib_pos;
    logic [3:0]        nib;
    logic [CHAR_W-1:0] c;
    nib_pos = d.tlen - 5'd1 - j;
    nib     = d.value[{nib_pos[3:0], 2'b00} +: 4];
    if (d.is_nil) begin
      case (j)
        5'd0:    c = CH_LPAREN;
        5'd1:    c = CH_N;
        5'd2:    c = CH_I;
        5'd3:    c = CH_L;
        default: c = CH_RPAREN;
      endcase
    end else if (j == 5'd0) begin
      c = CH_ZERO;
    end else if (j == 5'd1) begin
      c = CH_X;
    end else if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = CH_HEX_A_OFS + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

[src/hpf_front.sv]
// Front end: takes input transactions and classifies them into a descriptor
// (text length, padding, total). Depends on hpf_pkg.
module hpf_front #(
  parameter int MAX_FIELD_WIDTH = hpf_pkg::DEF_MAX_FIELD_WIDTH
) (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            push_valid,
  input  logic                            push_ready,
  output hpf_pkg::desc_t                  push_desc
);
  import hpf_pkg::*;

  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_FIELD_WIDTH);

  logic [PTR_W-1:0]   value;
  logic [WIDTH_W-1:0] fw;
  logic [WIDTH_W-1:0] width_sat;
  logic [TLEN_W-1:0]  ndig;
  logic [TLEN_W-1:0]  tlen;
  logic [WIDTH_W-1:0] total;

  assign value = in_tdata[PTR_W-1:0];
  assign fw    = in_tdata[PTR_W +: WIDTH_W];

  // Highest nonzero nibble sets the digit count
  always_comb begin
    ndig = 5'd1;
    for (int i = 1; i < 16; i++) begin
      if (value[i*4 +: 4] != 4'd0) begin
        ndig = TLEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    width_sat = (fw > MAX_W) ? MAX_W : fw;
    tlen      = (value == '0) ? NIL_LEN : ndig + 5'd2;
    total     = (width_sat > {2'b00, tlen}) ? width_sat : {2'b00, tlen};
    push_desc.value  = value;
    push_desc.is_nil = (value == '0);
    push_desc.tlen   = tlen;
    push_desc.pad    = total - {2'b00, tlen};
    push_desc.total  = total;
    push_desc.left   = in_tdata[PTR_W + WIDTH_W];
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

[src/hpf_queue.sv]
// Short descriptor queue between front and back so each side stalls alone.
// Depends on hpf_pkg.
module hpf_queue (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        push_valid,
  output logic                                        push_ready,
  input  hpf_pkg::desc_t                              push_desc,
  output logic                                        pop_valid,
  input  logic                                        pop,
  output hpf_pkg::desc_t                              pop_desc,
  output logic [$clog2(hpf_pkg::QUEUE_DEPTH+1)-1:0]   count
);
  import hpf_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

  desc_t            entry_r [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != DEPTH_C);
  assign pop_valid  = (count_r != '0);
  assign pop_desc   = entry_r[rd_ptr_r];
  assign count      = count_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[src/hpf_back.sv]
// Back end: walks the head descriptor one character per cycle into the
// output register while out_tready allows. Depends on hpf_pkg.
module hpf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             head_valid,
  input  hpf_pkg::desc_t                   head_desc,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hpf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import hpf_pkg::*;

  logic [WIDTH_W-1:0] k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  char_r;
  logic [WIDTH_W-1:0] total_r;
  logic               last_r;
  logic               load;
  logic               is_last;
  logic               in_txt;
  logic [WIDTH_W-1:0] j;
  logic [CHAR_W-1:0]  char_nxt;

  always_comb begin
    load    = head_valid && (!out_valid_r || out_tready);
    is_last = (k_r + 7'd1 == head_desc.total);
    if (head_desc.left) begin
      in_txt = (k_r < {2'b00, head_desc.tlen});
      j      = k_r;
    end else begin
      in_txt = (k_r >= head_desc.pad);
      j      = k_r - head_desc.pad;
    end
    char_nxt = in_txt ? txt_char(head_desc, j[TLEN_W-1:0]) : CH_SPACE;
    pop      = load && is_last;
    k_nxt    = k_r;
    if (load) begin
      k_nxt = is_last ? '0 : k_r + 7'd1;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      char_r  <= char_nxt;
      total_r <= head_desc.total;
      last_r  <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, total_r, char_r};
  assign out_tlast  = last_r;

endmodule

[src/hex_pointer_field_formatter.sv]
// Top level of the hex pointer formatter: front end, descriptor queue, back end.
// Depends on hpf_pkg, hpf_front, hpf_queue and hpf_back.
//
// Formats a 64-bit pointer as "%p" text ("0x" plus lowercase hex digits, or
// "(nil)" for zero), space padded to field_width (saturated at MAX_FIELD_WIDTH),
// and sends one character per output transaction. An item is max(text length,
// saturated width) characters long, at least 3, and the back end's character
// counter emits one character per cycle unless out_tready stalls it. The front end
// classifies an item in the cycle it is accepted and a two-entry queue holds it,
// so the next item is taken while the current one is still being emitted and
// characters of consecutive items leave without a gap.
module hex_pointer_field_formatter #(
  parameter int MAX_FIELD_WIDTH = hpf_pkg::DEF_MAX_FIELD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] pointer_value, [70:64] field_width, [71] left_justify
  input  logic [hpf_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_char, [14:8] total_chars, [15] zero
  output logic [hpf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tlast
);
  import hpf_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            push_desc;
  desc_t            head_desc;
  logic             push_valid;
  logic             push_ready;
  logic             head_valid;
  logic             pop;
  logic [CNT_W-1:0] q_count;

  hpf_front #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  hpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_desc   (head_desc),
    .count      (q_count)
  );

  hpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("descriptor queue count above depth");

  a_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> head_valid)
    else $error("non-final character shown with no item at queue head");

  a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:8] >= 7'd3))
    else $error("total character count below three");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_tvalid && out_tlast))
    else $error("queue entry released without final character loaded");

endmodule
